[design/bpts_pkg.sv]
package bpts_pkg;

   // Slot number layout: group in the upper bits, position in the lower bits.
   localparam int ID_W  = 6;
   localparam int GRP_W = 3;
   localparam int POS_W = 3;

   typedef logic [ID_W-1:0]  slot_type;
   typedef logic [GRP_W-1:0] grp_type;
   typedef logic [POS_W-1:0] pos_type;

   typedef enum logic [2:0] {
      CMD_CREATE        = 3'd0,
      CMD_SET_READY     = 3'd1,
      CMD_CLEAR_READY   = 3'd2,
      CMD_SET_PENDING   = 3'd3,
      CMD_CLEAR_PENDING = 3'd4,
      CMD_SET_BLOCK     = 3'd5,
      CMD_CLEAR_BLOCK   = 3'd6,
      CMD_QUERY         = 3'd7
   } cmd_type;

   typedef enum logic [1:0] {
      SRC_READY   = 2'd0,
      SRC_PENDING = 2'd1,
      SRC_CURRENT = 2'd2
   } src_type;

   typedef struct packed {
      cmd_type  command;
      slot_type task_id;
      logic     current_valid;
      slot_type current_id;
   } req_type;

   typedef struct packed {
      logic     accepted;
      logic     ready_found;
      slot_type ready_slot;
      logic     pending_found;
      slot_type pending_slot;
      logic     pick_found;
      slot_type pick_slot;
      src_type  pick_source;
   } rsp_type;

   // Outcome of a lowest-set-bit lookup in one two-level map.
   typedef struct packed {
      logic     any;
      logic     hit;
      slot_type slot;
   } find_type;

endpackage

[design/bpts_lowest_find.sv]
module bpts_lowest_find #(
   parameter int GROUP_COUNT     = 8,
   parameter int TASKS_PER_GROUP = 8
) (
   input  logic [GROUP_COUNT-1:0][TASKS_PER_GROUP-1:0] map_bits,
   input  logic [GROUP_COUNT-1:0][TASKS_PER_GROUP-1:0] occ_bits,
   output logic [GROUP_COUNT-1:0][TASKS_PER_GROUP-1:0] pick_mask,
   output bpts_pkg::find_type                          result
);

   logic [GROUP_COUNT-1:0]     grp_any;
   logic [GROUP_COUNT-1:0]     grp_hot;
   logic [TASKS_PER_GROUP-1:0] row;
   logic [TASKS_PER_GROUP-1:0] pos_hot;
   logic                       grp_seen;
   logic                       pos_seen;
   bpts_pkg::grp_type          grp_idx;
   bpts_pkg::pos_type          pos_idx;

   always_comb begin
      grp_seen = 1'b0;
      grp_idx  = '0;
      row      = '0;
      for (int g = 0; g < GROUP_COUNT; g++) begin
         grp_any[g] = |map_bits[g];
         grp_hot[g] = grp_any[g] & ~grp_seen;
         grp_seen   = grp_seen | grp_any[g];
         if (grp_hot[g]) begin
            grp_idx = bpts_pkg::grp_type'(g);
            row     = map_bits[g];
         end
      end

      pos_seen = 1'b0;
      pos_idx  = '0;
      for (int t = 0; t < TASKS_PER_GROUP; t++) begin
         pos_hot[t] = row[t] & ~pos_seen;
         pos_seen   = pos_seen | row[t];
         if (pos_hot[t]) begin
            pos_idx = bpts_pkg::pos_type'(t);
         end
      end

      for (int g = 0; g < GROUP_COUNT; g++) begin
         for (int t = 0; t < TASKS_PER_GROUP; t++) begin
            pick_mask[g][t] = grp_hot[g] & pos_hot[t];
         end
      end

      result.any  = grp_seen;
      result.hit  = |(pick_mask & occ_bits);
      result.slot = {grp_idx, pos_idx};
   end

endmodule

[design/bitmap_priority_task_selector_core.sv]
// Task selector over GROUP_COUNT x TASKS_PER_GROUP slots (slot = group * 8 + position,
// lower number wins). Each request transaction carries one command (create, set or clear
// a ready/pending/block bit, or query) plus the running task, and yields exactly one
// response transaction: the lowest occupied ready and pending slots and the slot to run
// next, with the running task kept on ties. A ready or pending bit found on an unoccupied
// slot is dropped during that lookup and reported as not found. A request is registered,
// decoded, applied to the maps and looked up in one combinational pass, and the response
// is registered; one request per cycle is sustained while rsp_stall is low. The maps
// reset to empty with no clearing pass.
module bitmap_priority_task_selector_core #(
   parameter int GROUP_COUNT     = 8,
   parameter int TASKS_PER_GROUP = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  bpts_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output bpts_pkg::rsp_type rsp_data
);

   localparam logic [bpts_pkg::GRP_W:0] GroupLimit = (bpts_pkg::GRP_W + 1)'(GROUP_COUNT);
   localparam logic [bpts_pkg::POS_W:0] PosLimit   = (bpts_pkg::POS_W + 1)'(TASKS_PER_GROUP);

   typedef logic [GROUP_COUNT-1:0][TASKS_PER_GROUP-1:0] map_type;

   map_type occupied_ff, occupied_in;
   map_type ready_ff, ready_in;
   map_type pending_ff, pending_in;
   map_type blocked_ff, blocked_in;

   logic              item_valid_ff;
   bpts_pkg::req_type item_ff;
   logic              rsp_valid_ff;
   bpts_pkg::rsp_type rsp_ff, rsp_in;

   logic item_advance;
   logic rsp_load;

   map_type ready_cmd, pending_cmd;
   map_type id_mask, cur_mask, ready_mask, pending_mask;
   logic    id_in_range, cur_in_range;
   logic    ready_ok, pending_ok, cur_ok;
   logic    cmd_accepted;

   bpts_pkg::find_type ready_find, pending_find;
   bpts_pkg::grp_type  id_grp, cur_grp;
   bpts_pkg::pos_type  id_pos, cur_pos;

   // Response register frees up when empty or being taken.
   assign rsp_load     = !rsp_valid_ff || !rsp_stall;
   assign item_advance = item_valid_ff && rsp_load;
   assign req_stall    = item_valid_ff && !rsp_load;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_ff;

   assign {id_grp, id_pos}   = item_ff.task_id;
   assign {cur_grp, cur_pos} = item_ff.current_id;

   always_comb begin
      id_in_range  = ({1'b0, id_grp} < GroupLimit) && ({1'b0, id_pos} < PosLimit);
      cur_in_range = item_ff.current_valid &&
                     ({1'b0, cur_grp} < GroupLimit) && ({1'b0, cur_pos} < PosLimit);
      for (int g = 0; g < GROUP_COUNT; g++) begin
         for (int t = 0; t < TASKS_PER_GROUP; t++) begin
            id_mask[g][t]  = id_in_range && (id_grp == bpts_pkg::grp_type'(g)) &&
                             (id_pos == bpts_pkg::pos_type'(t));
            cur_mask[g][t] = cur_in_range && (cur_grp == bpts_pkg::grp_type'(g)) &&
                             (cur_pos == bpts_pkg::pos_type'(t));
         end
      end
   end

   // Command stage: out-of-range slots give an empty mask, so nothing changes.
   always_comb begin
      occupied_in  = occupied_ff;
      ready_cmd    = ready_ff;
      pending_cmd  = pending_ff;
      blocked_in   = blocked_ff;
      cmd_accepted = 1'b1;
      unique case (item_ff.command)
         bpts_pkg::CMD_CREATE: begin
            if (|(id_mask & occupied_ff)) begin
               cmd_accepted = 1'b0;
            end else begin
               occupied_in = occupied_ff | id_mask;
               ready_cmd   = ready_ff | id_mask;
            end
         end
         bpts_pkg::CMD_SET_READY:     ready_cmd   = ready_ff | id_mask;
         bpts_pkg::CMD_CLEAR_READY:   ready_cmd   = ready_ff & ~id_mask;
         bpts_pkg::CMD_SET_PENDING:   pending_cmd = pending_ff | id_mask;
         bpts_pkg::CMD_CLEAR_PENDING: pending_cmd = pending_ff & ~id_mask;
         bpts_pkg::CMD_SET_BLOCK:     blocked_in  = blocked_ff | id_mask;
         bpts_pkg::CMD_CLEAR_BLOCK:   blocked_in  = blocked_ff & ~id_mask;
         bpts_pkg::CMD_QUERY: begin
         end
         default: begin
         end
      endcase
   end

   bpts_lowest_find #(
      .GROUP_COUNT     (GROUP_COUNT),
      .TASKS_PER_GROUP (TASKS_PER_GROUP)
   ) u_ready_find (
      .map_bits  (ready_cmd),
      .occ_bits  (occupied_in),
      .pick_mask (ready_mask),
      .result    (ready_find)
   );

   bpts_lowest_find #(
      .GROUP_COUNT     (GROUP_COUNT),
      .TASKS_PER_GROUP (TASKS_PER_GROUP)
   ) u_pending_find (
      .map_bits  (pending_cmd),
      .occ_bits  (occupied_in),
      .pick_mask (pending_mask),
      .result    (pending_find)
   );

   always_comb begin
      // Stale bit on an empty slot: drop it, report nothing.
      ready_in   = (ready_find.any && !ready_find.hit) ? (ready_cmd & ~ready_mask) : ready_cmd;
      pending_in = (pending_find.any && !pending_find.hit) ?
                   (pending_cmd & ~pending_mask) : pending_cmd;

      ready_ok   = ready_find.hit && !(|(ready_mask & blocked_in));
      pending_ok = pending_find.hit && !(|(pending_mask & blocked_in));
      cur_ok     = cur_in_range && !(|(cur_mask & blocked_in));

      rsp_in.accepted      = cmd_accepted;
      rsp_in.ready_found   = ready_find.hit;
      rsp_in.ready_slot    = ready_find.hit ? ready_find.slot : '0;
      rsp_in.pending_found = pending_find.hit;
      rsp_in.pending_slot  = pending_find.hit ? pending_find.slot : '0;

      // Later candidates win ties.
      rsp_in.pick_found  = 1'b0;
      rsp_in.pick_slot   = '0;
      rsp_in.pick_source = bpts_pkg::SRC_READY;
      if (ready_ok) begin
         rsp_in.pick_found  = 1'b1;
         rsp_in.pick_slot   = ready_find.slot;
         rsp_in.pick_source = bpts_pkg::SRC_READY;
      end
      if (pending_ok && (!rsp_in.pick_found || pending_find.slot <= rsp_in.pick_slot)) begin
         rsp_in.pick_found  = 1'b1;
         rsp_in.pick_slot   = pending_find.slot;
         rsp_in.pick_source = bpts_pkg::SRC_PENDING;
      end
      if (cur_ok && (!rsp_in.pick_found || item_ff.current_id <= rsp_in.pick_slot)) begin
         rsp_in.pick_found  = 1'b1;
         rsp_in.pick_slot   = item_ff.current_id;
         rsp_in.pick_source = bpts_pkg::SRC_CURRENT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         occupied_ff   <= '0;
         ready_ff      <= '0;
         pending_ff    <= '0;
         blocked_ff    <= '0;
      end else begin
         if (!req_stall) begin
            item_valid_ff <= req_valid;
         end
         if (rsp_load) begin
            rsp_valid_ff <= item_valid_ff;
         end
         if (item_advance) begin
            occupied_ff <= occupied_in;
            ready_ff    <= ready_in;
            pending_ff  <= pending_in;
            blocked_ff  <= blocked_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         item_ff <= req_data;
      end
      if (item_advance) begin
         rsp_ff <= rsp_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_item_reaches_output: assert property (@(posedge clock) disable iff (reset)
      item_advance |=> rsp_valid_ff)
      else $error("advanced transaction did not reach the response register");

   a_pick_ready_consistent: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.pick_found && rsp_data.pick_source == bpts_pkg::SRC_READY) |->
      (rsp_data.ready_found && rsp_data.pick_slot == rsp_data.ready_slot))
      else $error("ready pick does not match the ready lookup");

   a_pick_pending_consistent: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.pick_found && rsp_data.pick_source == bpts_pkg::SRC_PENDING) |->
      (rsp_data.pending_found && rsp_data.pick_slot == rsp_data.pending_slot))
      else $error("pending pick does not match the pending lookup");
`endif

endmodule
